// ===== hw/rtl/dbad_pkg.sv =====
package dbad_pkg;

    // Build-time constants of the block.
    localparam int GRID_SIZE      = 320;
    localparam int MAX_DETECTIONS = 128;
    localparam int FILTER_SLOTS   = 8;

    // Field widths.
    localparam int CLS_W      = 8;
    localparam int SCORE_W    = 16;
    localparam int NORM_W     = 18;
    localparam int SIZE_W     = 13;
    localparam int PIX_W      = 12;
    localparam int FRAC_W     = 17;
    localparam int DIR_W      = 2;
    localparam int COUNT_W    = 8;
    localparam int SUM_W      = 24;
    localparam int IDS_W      = 64;
    localparam int FCNT_W     = 4;
    localparam int FRAC_SHIFT = 16;

    localparam int FRAC_ONE = 65536;
    localparam int SIZE_MAX = 4096;
    localparam int PIX_MAX  = 4095;

    // Four corners of a box, in the order they pass the pixel mapper.
    localparam int NUM_COORDS = 4;
    localparam int TAG_W      = 2;
    localparam logic [TAG_W-1:0] COORD_LEFT   = 2'd0;
    localparam logic [TAG_W-1:0] COORD_TOP    = 2'd1;
    localparam logic [TAG_W-1:0] COORD_RIGHT  = 2'd2;
    localparam logic [TAG_W-1:0] COORD_BOTTOM = 2'd3;

    // Direction codes: low side is left or up, high side is right or down.
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LOW  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_HIGH = 2'd2;

    // Register map.
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CONF_MIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_H_EDGE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_V_EDGE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_H_SPAN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_V_SPAN     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CLASS_IDS  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CLASS_CNT  = 3'd6;

    localparam logic [SCORE_W-1:0] RST_CONF_MIN  = 16'd32768;
    localparam logic [FRAC_W-1:0]  RST_H_EDGE    = 17'd13107;
    localparam logic [FRAC_W-1:0]  RST_V_EDGE    = 17'd13107;
    localparam logic [FRAC_W-1:0]  RST_H_SPAN    = 17'd26214;
    localparam logic [FRAC_W-1:0]  RST_V_SPAN    = 17'd58982;

    typedef struct packed {
        logic [SCORE_W-1:0] conf_min;
        logic [FRAC_W-1:0]  h_edge;
        logic [FRAC_W-1:0]  v_edge;
        logic [FRAC_W-1:0]  h_span;
        logic [FRAC_W-1:0]  v_span;
        logic [IDS_W-1:0]   class_ids;
        logic [FCNT_W-1:0]  class_cnt;
    } t_cfg;

    typedef struct packed {
        logic             capture;
        logic             map_issue;
        logic [TAG_W-1:0] map_sel;
        logic             accumulate;
        logic             clear;
        logic             div_start;
        logic             div_step;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic keep_in;
        logic map_busy;
        logic item_last;
        logic kept_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/dbad_in_if.sv =====
interface dbad_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [dbad_pkg::CLS_W-1:0]              class_code;
    logic [dbad_pkg::SCORE_W-1:0]            score;
    logic signed [dbad_pkg::NORM_W-1:0]      left_norm;
    logic signed [dbad_pkg::NORM_W-1:0]      top_norm;
    logic signed [dbad_pkg::NORM_W-1:0]      right_norm;
    logic signed [dbad_pkg::NORM_W-1:0]      bottom_norm;
    logic [dbad_pkg::SIZE_W-1:0]             frame_width;
    logic [dbad_pkg::SIZE_W-1:0]             frame_height;
    logic                                    frame_last;

    modport source (
        output valid, class_code, score, left_norm, top_norm, right_norm,
               bottom_norm, frame_width, frame_height, frame_last,
        input  ready
    );
    modport sink (
        input  valid, class_code, score, left_norm, top_norm, right_norm,
               bottom_norm, frame_width, frame_height, frame_last,
        output ready
    );
endinterface

// ===== hw/rtl/dbad_out_if.sv =====
interface dbad_out_if;
    logic                          valid;
    logic                          ready;
    logic [dbad_pkg::PIX_W-1:0]    center_x_avg;
    logic [dbad_pkg::PIX_W-1:0]    center_y_avg;
    logic [dbad_pkg::DIR_W-1:0]    horizontal_dir;
    logic [dbad_pkg::DIR_W-1:0]    vertical_dir;
    logic [dbad_pkg::COUNT_W-1:0]  kept_count;

    modport source (
        output valid, center_x_avg, center_y_avg, horizontal_dir, vertical_dir,
               kept_count,
        input  ready
    );
    modport sink (
        input  valid, center_x_avg, center_y_avg, horizontal_dir, vertical_dir,
               kept_count,
        output ready
    );
endinterface

// ===== hw/rtl/dbad_regs.sv =====
module dbad_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbad_pkg::PADDR_W-1:0]  paddr,
    input  logic [dbad_pkg::PDATA_W-1:0]  pwdata,
    output logic [dbad_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output dbad_pkg::t_cfg                o_cfg
);

    dbad_pkg::t_cfg                      r_cfg;
    logic                                w_wr;
    logic [dbad_pkg::REG_IDX_W-1:0]      w_idx;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[dbad_pkg::PADDR_W-1:3];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conf_min  <= dbad_pkg::RST_CONF_MIN;
            r_cfg.h_edge    <= dbad_pkg::RST_H_EDGE;
            r_cfg.v_edge    <= dbad_pkg::RST_V_EDGE;
            r_cfg.h_span    <= dbad_pkg::RST_H_SPAN;
            r_cfg.v_span    <= dbad_pkg::RST_V_SPAN;
            r_cfg.class_ids <= '0;
            r_cfg.class_cnt <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                dbad_pkg::REG_CONF_MIN:  r_cfg.conf_min  <= pwdata[dbad_pkg::SCORE_W-1:0];
                dbad_pkg::REG_H_EDGE:    r_cfg.h_edge    <= pwdata[dbad_pkg::FRAC_W-1:0];
                dbad_pkg::REG_V_EDGE:    r_cfg.v_edge    <= pwdata[dbad_pkg::FRAC_W-1:0];
                dbad_pkg::REG_H_SPAN:    r_cfg.h_span    <= pwdata[dbad_pkg::FRAC_W-1:0];
                dbad_pkg::REG_V_SPAN:    r_cfg.v_span    <= pwdata[dbad_pkg::FRAC_W-1:0];
                dbad_pkg::REG_CLASS_IDS: r_cfg.class_ids <= pwdata[dbad_pkg::IDS_W-1:0];
                dbad_pkg::REG_CLASS_CNT: r_cfg.class_cnt <= pwdata[dbad_pkg::FCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            dbad_pkg::REG_CONF_MIN:  prdata = dbad_pkg::PDATA_W'(r_cfg.conf_min);
            dbad_pkg::REG_H_EDGE:    prdata = dbad_pkg::PDATA_W'(r_cfg.h_edge);
            dbad_pkg::REG_V_EDGE:    prdata = dbad_pkg::PDATA_W'(r_cfg.v_edge);
            dbad_pkg::REG_H_SPAN:    prdata = dbad_pkg::PDATA_W'(r_cfg.h_span);
            dbad_pkg::REG_V_SPAN:    prdata = dbad_pkg::PDATA_W'(r_cfg.v_span);
            dbad_pkg::REG_CLASS_IDS: prdata = dbad_pkg::PDATA_W'(r_cfg.class_ids);
            dbad_pkg::REG_CLASS_CNT: prdata = dbad_pkg::PDATA_W'(r_cfg.class_cnt);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/dbad_pixmap.sv =====
module dbad_pixmap (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [dbad_pkg::TAG_W-1:0]          i_tag,
    input  logic signed [dbad_pkg::NORM_W-1:0]  i_coord,
    input  logic [dbad_pkg::SIZE_W-1:0]         i_size,
    output logic                                o_valid,
    output logic [dbad_pkg::TAG_W-1:0]          o_tag,
    output logic [dbad_pkg::PIX_W-1:0]          o_px,
    output logic                                o_busy
);

    // A positive coordinate below two gives a grid cell below 2*GRID_SIZE.
    localparam int CELL_W = $clog2(2 * dbad_pkg::GRID_SIZE);
    localparam int SCL_W  = dbad_pkg::FRAC_SHIFT + CELL_W;
    localparam int PROD_W = CELL_W + dbad_pkg::SIZE_W;
    localparam int QUO_W  = dbad_pkg::SIZE_W;
    // Floor reciprocal of the grid size; the quotient it gives is low by at most one.
    localparam logic [PROD_W-1:0] RECIP =
        PROD_W'((64'd1 << PROD_W) / dbad_pkg::GRID_SIZE);

    logic [3:0]                     r_vld;
    logic [dbad_pkg::TAG_W-1:0]     r_tag1, r_tag2, r_tag3, r_tag4;
    logic [dbad_pkg::SIZE_W-1:0]    r_sz1, r_sz2, r_sz3;
    logic [CELL_W-1:0]              r_cell;
    logic [PROD_W-1:0]              r_prod, r_prod3;
    logic [QUO_W-1:0]               r_q0;
    logic [dbad_pkg::PIX_W-1:0]     r_px;

    logic [SCL_W-1:0]               w_scaled;
    logic [CELL_W-1:0]              w_cell;
    logic [PROD_W-1:0]              w_prod;
    logic [2*PROD_W-1:0]            w_mul;
    logic [QUO_W-1:0]               w_q0;
    logic [PROD_W-1:0]              w_back;
    logic [PROD_W-1:0]              w_rem;
    logic [QUO_W-1:0]               w_q;
    logic [dbad_pkg::SIZE_W-1:0]    w_lim;
    logic [dbad_pkg::PIX_W-1:0]     w_px;

    // Normalized coordinate to grid cell; zero and negative map to cell zero.
    assign w_scaled = SCL_W'(dbad_pkg::GRID_SIZE) * SCL_W'(i_coord[dbad_pkg::NORM_W-2:0]);
    assign w_cell   = i_coord[dbad_pkg::NORM_W-1] ? '0
                                                  : w_scaled[SCL_W-1:dbad_pkg::FRAC_SHIFT];

    assign w_prod = PROD_W'(r_cell) * PROD_W'(r_sz1);

    assign w_mul = (2*PROD_W)'(r_prod) * (2*PROD_W)'(RECIP);
    assign w_q0  = w_mul[PROD_W+QUO_W-1:PROD_W];

    assign w_back = PROD_W'(r_q0) * PROD_W'(dbad_pkg::GRID_SIZE);
    assign w_rem  = r_prod3 - w_back;
    assign w_q    = r_q0 + QUO_W'(w_rem >= PROD_W'(dbad_pkg::GRID_SIZE));
    assign w_lim  = r_sz3 - dbad_pkg::SIZE_W'(1);
    assign w_px   = (w_q > w_lim) ? w_lim[dbad_pkg::PIX_W-1:0] : w_q[dbad_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1  <= i_tag;
        r_sz1   <= i_size;
        r_cell  <= w_cell;
        r_tag2  <= r_tag1;
        r_sz2   <= r_sz1;
        r_prod  <= w_prod;
        r_tag3  <= r_tag2;
        r_sz3   <= r_sz2;
        r_prod3 <= r_prod;
        r_q0    <= w_q0;
        r_tag4  <= r_tag3;
        r_px    <= w_px;
    end

    assign o_valid = r_vld[3];
    assign o_tag   = r_tag4;
    assign o_px    = r_px;
    assign o_busy  = |r_vld;

endmodule

// ===== hw/rtl/dbad_dpath.sv =====
module dbad_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dbad_pkg::t_cfg                      i_cfg,
    input  dbad_pkg::t_cmd                      i_cmd,
    output dbad_pkg::t_sts                      o_sts,
    input  logic [dbad_pkg::CLS_W-1:0]          i_class_code,
    input  logic [dbad_pkg::SCORE_W-1:0]        i_score,
    input  logic signed [dbad_pkg::NORM_W-1:0]  i_left_norm,
    input  logic signed [dbad_pkg::NORM_W-1:0]  i_top_norm,
    input  logic signed [dbad_pkg::NORM_W-1:0]  i_right_norm,
    input  logic signed [dbad_pkg::NORM_W-1:0]  i_bottom_norm,
    input  logic [dbad_pkg::SIZE_W-1:0]         i_frame_width,
    input  logic [dbad_pkg::SIZE_W-1:0]         i_frame_height,
    input  logic                                i_frame_last,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [dbad_pkg::PIX_W-1:0]          o_center_x_avg,
    output logic [dbad_pkg::PIX_W-1:0]          o_center_y_avg,
    output logic [dbad_pkg::DIR_W-1:0]          o_horizontal_dir,
    output logic [dbad_pkg::DIR_W-1:0]          o_vertical_dir,
    output logic [dbad_pkg::COUNT_W-1:0]        o_kept_count
);

    localparam int PIX_W  = dbad_pkg::PIX_W;
    localparam int SUM_W  = dbad_pkg::SUM_W;
    localparam int DVS_W  = dbad_pkg::COUNT_W + 1;
    localparam int REM_W  = DVS_W;
    localparam int MUL1_W = dbad_pkg::SIZE_W + dbad_pkg::FRAC_W;
    localparam int MUL2_W = MUL1_W + DVS_W;
    localparam int LHS_W  = SUM_W + dbad_pkg::FRAC_SHIFT;
    localparam int EXT_W  = PIX_W + dbad_pkg::FRAC_SHIFT;

    // Current item.
    logic signed [dbad_pkg::NORM_W-1:0] r_coord [dbad_pkg::NUM_COORDS];
    logic [dbad_pkg::SIZE_W-1:0]        r_w, r_h;
    logic                               r_last;
    logic [PIX_W-1:0]                   r_px [dbad_pkg::NUM_COORDS];

    // Frame accumulators.
    logic [dbad_pkg::COUNT_W-1:0]       r_kept;
    logic [SUM_W-1:0]                   r_xsum, r_ysum;
    logic [PIX_W-1:0]                   r_xlo, r_xhi, r_ylo, r_yhi;

    // Average dividers.
    logic [REM_W-1:0]                   r_xrem, r_yrem;
    logic [PIX_W-1:0]                   r_xq, r_yq;

    // Threshold products.
    logic [MUL1_W-1:0]                  r_hlo, r_hhi, r_hspan, r_vlo, r_vhi, r_vspan;
    logic [MUL2_W-1:0]                  r_hlo2, r_hhi2, r_vlo2, r_vhi2;

    // Result register.
    logic                               r_out_valid;
    logic [PIX_W-1:0]                   r_out_cx, r_out_cy;
    logic [dbad_pkg::DIR_W-1:0]         r_out_hdir, r_out_vdir;
    logic [dbad_pkg::COUNT_W-1:0]       r_out_kept;

    logic                               w_score_ok;
    logic [dbad_pkg::FCNT_W-1:0]        w_cnt_eff;
    logic                               w_hit;
    logic                               w_keep;
    logic [dbad_pkg::SIZE_W-1:0]        w_w_in, w_h_in;
    logic                               w_map_valid;
    logic [dbad_pkg::TAG_W-1:0]         w_map_tag;
    logic [PIX_W-1:0]                   w_map_px;
    logic                               w_map_busy;
    logic [dbad_pkg::NORM_W-1:0]        w_sel_coord;
    logic [dbad_pkg::SIZE_W-1:0]        w_sel_size;
    logic [PIX_W-1:0]                   w_x1, w_y1, w_x2, w_y2;
    logic [PIX_W-1:0]                   w_xmin, w_xmax, w_ymin, w_ymax;
    logic [DVS_W-1:0]                   w_div;
    logic [REM_W:0]                     w_xtrial, w_ytrial;
    logic                               w_xge, w_yge;
    logic [dbad_pkg::FRAC_W-1:0]        w_he, w_ve, w_hs, w_vs;
    logic [PIX_W-1:0]                   w_xext, w_yext;
    logic [LHS_W-1:0]                   w_xlhs, w_ylhs;
    logic                               w_hspan_ok, w_vspan_ok;
    logic [dbad_pkg::DIR_W-1:0]         w_hdir, w_vdir;

    function automatic logic [dbad_pkg::SIZE_W-1:0] clamp_size(
        input logic [dbad_pkg::SIZE_W-1:0] s
    );
        if (s == '0) begin
            return dbad_pkg::SIZE_W'(1);
        end else if (s > dbad_pkg::SIZE_W'(dbad_pkg::SIZE_MAX)) begin
            return dbad_pkg::SIZE_W'(dbad_pkg::SIZE_MAX);
        end
        return s;
    endfunction

    function automatic logic [dbad_pkg::FRAC_W-1:0] clamp_frac(
        input logic [dbad_pkg::FRAC_W-1:0] f
    );
        return (f > dbad_pkg::FRAC_W'(dbad_pkg::FRAC_ONE))
            ? dbad_pkg::FRAC_W'(dbad_pkg::FRAC_ONE) : f;
    endfunction

    function automatic logic [dbad_pkg::DIR_W-1:0] pick_dir(
        input logic span_ok,
        input logic below,
        input logic above
    );
        if (!span_ok) begin
            return dbad_pkg::DIR_NONE;
        end else if (below) begin
            return dbad_pkg::DIR_LOW;
        end else if (above) begin
            return dbad_pkg::DIR_HIGH;
        end
        return dbad_pkg::DIR_NONE;
    endfunction

    // Keep decision on the offered item.
    assign w_score_ok = i_score > i_cfg.conf_min;
    assign w_cnt_eff  = (i_cfg.class_cnt > dbad_pkg::FCNT_W'(dbad_pkg::FILTER_SLOTS))
                        ? dbad_pkg::FCNT_W'(dbad_pkg::FILTER_SLOTS) : i_cfg.class_cnt;

    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < dbad_pkg::FILTER_SLOTS; i++) begin
            if ((dbad_pkg::FCNT_W'(i) < w_cnt_eff) &&
                (i_cfg.class_ids[8*i +: 8] == i_class_code)) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_keep = w_score_ok && ((i_cfg.class_cnt == '0) || w_hit) &&
                    (r_kept < dbad_pkg::COUNT_W'(dbad_pkg::MAX_DETECTIONS));

    assign w_w_in = clamp_size(i_frame_width);
    assign w_h_in = clamp_size(i_frame_height);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_coord[dbad_pkg::COORD_LEFT]   <= i_left_norm;
            r_coord[dbad_pkg::COORD_TOP]    <= i_top_norm;
            r_coord[dbad_pkg::COORD_RIGHT]  <= i_right_norm;
            r_coord[dbad_pkg::COORD_BOTTOM] <= i_bottom_norm;
            r_w    <= w_w_in;
            r_h    <= w_h_in;
            r_last <= i_frame_last;
        end
        if (w_map_valid) begin
            r_px[w_map_tag] <= w_map_px;
        end
    end

    // Top and bottom scale by height, left and right by width.
    assign w_sel_coord = r_coord[i_cmd.map_sel];
    assign w_sel_size  = i_cmd.map_sel[0] ? r_h : r_w;

    dbad_pixmap u_pixmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.map_issue),
        .i_tag   (i_cmd.map_sel),
        .i_coord (w_sel_coord),
        .i_size  (w_sel_size),
        .o_valid (w_map_valid),
        .o_tag   (w_map_tag),
        .o_px    (w_map_px),
        .o_busy  (w_map_busy)
    );

    assign w_x1 = r_px[dbad_pkg::COORD_LEFT];
    assign w_y1 = r_px[dbad_pkg::COORD_TOP];
    assign w_x2 = r_px[dbad_pkg::COORD_RIGHT];
    assign w_y2 = r_px[dbad_pkg::COORD_BOTTOM];

    always_comb begin
        w_xmin = (w_x2 < w_x1) ? w_x2 : w_x1;
        w_xmax = (w_x2 > w_x1) ? w_x2 : w_x1;
        w_ymin = (w_y2 < w_y1) ? w_y2 : w_y1;
        w_ymax = (w_y2 > w_y1) ? w_y2 : w_y1;
        if (r_xlo < w_xmin) w_xmin = r_xlo;
        if (r_xhi > w_xmax) w_xmax = r_xhi;
        if (r_ylo < w_ymin) w_ymin = r_ylo;
        if (r_yhi > w_ymax) w_ymax = r_yhi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_kept <= '0;
            r_xsum <= '0;
            r_ysum <= '0;
            r_xlo  <= PIX_W'(dbad_pkg::PIX_MAX);
            r_xhi  <= '0;
            r_ylo  <= PIX_W'(dbad_pkg::PIX_MAX);
            r_yhi  <= '0;
        end else if (i_cmd.accumulate) begin
            r_kept <= r_kept + dbad_pkg::COUNT_W'(1);
            r_xsum <= r_xsum + SUM_W'(w_x1) + SUM_W'(w_x2);
            r_ysum <= r_ysum + SUM_W'(w_y1) + SUM_W'(w_y2);
            r_xlo  <= w_xmin;
            r_xhi  <= w_xmax;
            r_ylo  <= w_ymin;
            r_yhi  <= w_ymax;
        end
    end

    // Restoring division by twice the count, one quotient bit per cycle.
    // The quotient is known to fit in PIX_W bits, so the upper sum bits seed the remainder.
    assign w_div    = {r_kept, 1'b0};
    assign w_xtrial = {r_xrem, r_xq[PIX_W-1]};
    assign w_ytrial = {r_yrem, r_yq[PIX_W-1]};
    assign w_xge    = w_xtrial >= (REM_W+1)'(w_div);
    assign w_yge    = w_ytrial >= (REM_W+1)'(w_div);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_xrem <= r_xsum[PIX_W+REM_W-1:PIX_W];
            r_yrem <= r_ysum[PIX_W+REM_W-1:PIX_W];
            r_xq   <= r_xsum[PIX_W-1:0];
            r_yq   <= r_ysum[PIX_W-1:0];
        end else if (i_cmd.div_step) begin
            r_xrem <= w_xge ? REM_W'(w_xtrial - (REM_W+1)'(w_div)) : w_xtrial[REM_W-1:0];
            r_yrem <= w_yge ? REM_W'(w_ytrial - (REM_W+1)'(w_div)) : w_ytrial[REM_W-1:0];
            r_xq   <= {r_xq[PIX_W-2:0], w_xge};
            r_yq   <= {r_yq[PIX_W-2:0], w_yge};
        end
    end

    // Band and span thresholds. Their item operands stay put from the last item's capture,
    // or its accumulate step if it is kept, until the result is loaded, so the products have settled.
    assign w_he = clamp_frac(i_cfg.h_edge);
    assign w_ve = clamp_frac(i_cfg.v_edge);
    assign w_hs = clamp_frac(i_cfg.h_span);
    assign w_vs = clamp_frac(i_cfg.v_span);

    always_ff @(posedge i_clk) begin
        r_hlo   <= MUL1_W'(r_w) * MUL1_W'(w_he);
        r_hhi   <= MUL1_W'(r_w) * MUL1_W'(dbad_pkg::FRAC_W'(dbad_pkg::FRAC_ONE) - w_he);
        r_hspan <= MUL1_W'(r_w) * MUL1_W'(w_hs);
        r_vlo   <= MUL1_W'(r_h) * MUL1_W'(w_ve);
        r_vhi   <= MUL1_W'(r_h) * MUL1_W'(dbad_pkg::FRAC_W'(dbad_pkg::FRAC_ONE) - w_ve);
        r_vspan <= MUL1_W'(r_h) * MUL1_W'(w_vs);
        r_hlo2  <= MUL2_W'(r_hlo) * MUL2_W'(w_div);
        r_hhi2  <= MUL2_W'(r_hhi) * MUL2_W'(w_div);
        r_vlo2  <= MUL2_W'(r_vlo) * MUL2_W'(w_div);
        r_vhi2  <= MUL2_W'(r_vhi) * MUL2_W'(w_div);
    end

    assign w_xext = (r_xhi >= r_xlo) ? (r_xhi - r_xlo) : '0;
    assign w_yext = (r_yhi >= r_ylo) ? (r_yhi - r_ylo) : '0;
    assign w_hspan_ok = MUL1_W'(EXT_W'({w_xext, 16'd0})) < r_hspan;
    assign w_vspan_ok = MUL1_W'(EXT_W'({w_yext, 16'd0})) < r_vspan;
    assign w_xlhs = {r_xsum, 16'd0};
    assign w_ylhs = {r_ysum, 16'd0};
    assign w_hdir = pick_dir(w_hspan_ok, w_xlhs < LHS_W'(r_hlo2), w_xlhs > LHS_W'(r_hhi2));
    assign w_vdir = pick_dir(w_vspan_ok, w_ylhs < LHS_W'(r_vlo2), w_ylhs > LHS_W'(r_vhi2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cx   <= r_xq;
            r_out_cy   <= r_yq;
            r_out_hdir <= w_hdir;
            r_out_vdir <= w_vdir;
            r_out_kept <= r_kept;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_center_x_avg   = r_out_cx;
    assign o_center_y_avg   = r_out_cy;
    assign o_horizontal_dir = r_out_hdir;
    assign o_vertical_dir   = r_out_vdir;
    assign o_kept_count     = r_out_kept;

    assign o_sts.keep_in   = w_keep;
    assign o_sts.map_busy  = w_map_busy;
    assign o_sts.item_last = r_last;
    assign o_sts.kept_zero = (r_kept == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== hw/rtl/dbad_ctrl.sv =====
module dbad_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dbad_pkg::t_sts  i_sts,
    output dbad_pkg::t_cmd  o_cmd
);

    localparam int CNT_W = $clog2(dbad_pkg::PIX_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAP   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                n_cnt         = '0;
                if (i_in_valid) begin
                    n_state = i_sts.keep_in ? S_MAP : S_LAST;
                end
            end
            S_MAP: begin
                o_cmd.map_issue = 1'b1;
                o_cmd.map_sel   = r_cnt[dbad_pkg::TAG_W-1:0];
                if (r_cnt == CNT_W'(dbad_pkg::NUM_COORDS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_sts.map_busy) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state          = S_LAST;
            end
            S_LAST: begin
                if (!i_sts.item_last) begin
                    n_state = S_IDLE;
                end else if (i_sts.kept_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(dbad_pkg::PIX_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/detection_box_aggregate_direction.sv =====
// A detection is taken only in the idle state, so the next one waits until this one is through.
// A rejected detection passes the end-of-item step only; a kept one has its four corners sent
// through the four-stage pixel mapper, waits for its drain, then passes the accumulate and
// end-of-item steps. On the frame's last detection, if anything was kept, a bit-serial divide
// forms the average centers; the result is loaded once the previous one has left the output register.
// Reset: synchronous, active low; resets control, accumulators, output valid and the configuration registers.
module detection_box_aggregate_direction (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dbad_in_if.sink                       i_det,
    dbad_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbad_pkg::PADDR_W-1:0]  paddr,
    input  logic [dbad_pkg::PDATA_W-1:0]  pwdata,
    output logic [dbad_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // The register file holds the thresholds and the class filter list.
    // Each register sits at an 8-byte stride, since the class list is 64 bits wide.
    dbad_pkg::t_cfg w_cfg;
    dbad_pkg::t_cmd w_cmd;
    dbad_pkg::t_sts w_sts;
    logic           w_in_ready;

    dbad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller takes one detection per transaction. A kept detection
    // has its four corners mapped to pixels, then is added to the running sums and
    // the frame extent. On the frame's last detection the controller runs the
    // divide and loads the result register if anything was kept; either way
    // the frame accumulators are cleared for the next frame.
    dbad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_det.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_det.ready = w_in_ready;

    // The datapath holds the item, the pixel mapper, the accumulators, the two
    // dividers, the band products and the result register. The result register
    // lets a new detection be taken while the previous result is still waiting.
    dbad_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_class_code     (i_det.class_code),
        .i_score          (i_det.score),
        .i_left_norm      (i_det.left_norm),
        .i_top_norm       (i_det.top_norm),
        .i_right_norm     (i_det.right_norm),
        .i_bottom_norm    (i_det.bottom_norm),
        .i_frame_width    (i_det.frame_width),
        .i_frame_height   (i_det.frame_height),
        .i_frame_last     (i_det.frame_last),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_center_x_avg   (o_res.center_x_avg),
        .o_center_y_avg   (o_res.center_y_avg),
        .o_horizontal_dir (o_res.horizontal_dir),
        .o_vertical_dir   (o_res.vertical_dir),
        .o_kept_count     (o_res.kept_count)
    );

endmodule
